### hdl/fccl_pkg.sv
// Shared types and constants of the FAT cluster chain lookup unit.
`default_nettype none

package fccl_pkg;

    // Table geometry: the table is split into four byte banks.
    localparam int TABLE_BYTES = 65536;
    localparam int TABLE_AW    = $clog2(TABLE_BYTES);
    localparam int BANKS       = 4;
    localparam int ROW_AW      = TABLE_AW - 2;
    localparam int ROWS        = TABLE_BYTES / BANKS;

    // Byte offsets of entries are at most four times a 28-bit cluster.
    localparam int OFF_W = 30;
    localparam int END_W = OFF_W + 1;
    localparam logic [END_W-1:0] TABLE_END = END_W'(TABLE_BYTES);

    localparam int REG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FAT_KIND     = 2'd0,
        REG_SECTORS      = 2'd1,
        REG_DATA_START   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2
    } fat_kind_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    localparam logic [31:0] FAT12_MASK = 32'h0000_0FFF;
    localparam logic [31:0] FAT12_EOC  = 32'h0000_0FF8;
    localparam logic [31:0] FAT16_EOC  = 32'h0000_FFF8;
    localparam logic [31:0] FAT32_MASK = 32'h0FFF_FFFF;
    localparam logic [31:0] FAT32_EOC  = 32'h0FFF_FFF8;
    localparam logic [31:0] EOC_MARK   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  fat_kind;
        logic [7:0]  cluster_sectors;
        logic [31:0] data_region_start;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/fccl_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module fccl_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fccl_pkg::REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output fccl_pkg::cfg_t                      cfg
);
    import fccl_pkg::*;

    logic [1:0]  fat_kind_reg;
    logic [7:0]  spc_reg;
    logic [31:0] start_reg;
    logic        wr_en;
    logic [1:0]  index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_kind_reg <= KIND_FAT12;
            spc_reg      <= 8'd1;
            start_reg    <= 32'd0;
        end
        else if (wr_en)
        begin
            case (index)
                REG_FAT_KIND:   fat_kind_reg <= pwdata[1:0];
                REG_SECTORS:    spc_reg      <= pwdata[7:0];
                REG_DATA_START: start_reg    <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_FAT_KIND:   prdata = {30'd0, fat_kind_reg};
            REG_SECTORS:    prdata = {24'd0, spc_reg};
            REG_DATA_START: prdata = start_reg;
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.fat_kind            = fat_kind_reg;
    assign cfg.cluster_sectors     = spc_reg;
    assign cfg.data_region_start   = start_reg;

endmodule

`default_nettype wire

### hdl/fccl_table.sv
// Allocation table storage: four byte banks that return four consecutive bytes.
`default_nettype none

module fccl_table (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [fccl_pkg::TABLE_AW-1:0] waddr,
    input  wire logic [7:0]                   wdata,
    input  wire logic                         re,
    input  wire logic [fccl_pkg::TABLE_AW-1:0] raddr,
    output logic      [31:0]                  rdata
);
    import fccl_pkg::*;

    logic [7:0] rd_byte_reg [BANKS];
    logic [1:0] off_lo_reg;

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [7:0]        mem [ROWS];
        logic [ROW_AW-1:0] row;
        logic              bank_we;

        // Banks below the start byte hold bytes of the following row.
        assign row = raddr[TABLE_AW-1:2] + ROW_AW'(2'(b) < raddr[1:0]);
        assign bank_we = we && (waddr[1:0] == 2'(b));

        always_ff @(posedge clk)
        begin
            if (bank_we)
            begin
                mem[waddr[TABLE_AW-1:2]] <= wdata;
            end
            if (re)
            begin
                rd_byte_reg[b] <= mem[row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            off_lo_reg <= raddr[1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < BANKS; i++)
        begin
            rdata[8*i +: 8] = rd_byte_reg[off_lo_reg + 2'(i)];
        end
    end

endmodule

`default_nettype wire

### hdl/fat_cluster_chain_lookup_unit.sv
// Top level of the FAT cluster chain lookup unit.
`default_nettype none

// The unit takes one item per clock cycle when the result side keeps up. A write
// item stores one table byte and gives no result; a lookup item passes through
// the registered read of the four table banks and then through entry decoding
// and the first-sector multiply, which loads the output register. The input
// stalls only when that output register is full and stalled with a further
// lookup waiting behind it. Table contents are undefined after reset, so every
// entry must be written before it is looked up.
module fat_cluster_chain_lookup_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fccl_pkg::REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [15:0]                     table_address,
    input  wire logic [7:0]                      table_byte,
    input  wire logic [27:0]                     cluster,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [31:0]                     successor,
    output logic                                 end_of_chain,
    output logic      [31:0]                     first_sector,
    output logic                                 out_of_range
);
    import fccl_pkg::*;

    cfg_t cfg;

    logic               accept;
    logic               is_lookup;
    logic               tbl_we;
    logic [OFF_W-1:0]   offset;
    logic [END_W-1:0]   entry_end;
    logic               lookup_oor;
    logic [31:0]        rdata;

    logic               s1_valid_reg, s1_valid_next;
    logic [27:0]        s1_cl_reg;
    logic [1:0]         s1_kind_reg;
    logic               s1_oor_reg;
    logic               s1_adv;

    logic [31:0]        entry;
    logic [31:0]        limit;
    logic               eoc;
    logic [31:0]        next_val;
    logic [31:0]        cl_m2;
    logic [31:0]        product;
    logic [31:0]        sector;

    logic               out_valid_reg, out_valid_next;
    logic [31:0]        next_reg;
    logic               eoc_reg;
    logic [31:0]        sector_reg;
    logic               oor_reg;

    fccl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Entry offset and bounds of a lookup.
    always_comb
    begin
        case (cfg.fat_kind)
            KIND_FAT12:
            begin
                offset    = {2'd0, cluster} + {3'd0, cluster[27:1]};
                entry_end = {1'b0, offset} + END_W'(2);
            end
            KIND_FAT16:
            begin
                offset    = {1'b0, cluster, 1'b0};
                entry_end = {1'b0, offset} + END_W'(2);
            end
            default:
            begin
                offset    = {cluster, 2'b00};
                entry_end = {1'b0, offset} + END_W'(4);
            end
        endcase
    end

    assign lookup_oor = entry_end > TABLE_END;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign accept    = in_valid && !in_stall;
    assign is_lookup = (operation == OP_LOOKUP);
    assign tbl_we    = accept && !is_lookup && ({15'd0, table_address} < TABLE_END);

    fccl_table u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (TABLE_AW'(table_address)),
        .wdata (table_byte),
        .re    (accept && is_lookup),
        .raddr (offset[TABLE_AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = is_lookup;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // The kind is captured with the item so the decode matches the read.
    always_ff @(posedge clk)
    begin
        if (accept && is_lookup)
        begin
            s1_cl_reg   <= cluster;
            s1_kind_reg <= cfg.fat_kind;
            s1_oor_reg  <= lookup_oor;
        end
    end

    // Entry decode.
    always_comb
    begin
        case (s1_kind_reg)
            KIND_FAT12:
            begin
                entry = s1_cl_reg[0] ? {20'd0, rdata[15:4]} : (rdata & FAT12_MASK);
                limit = FAT12_EOC;
            end
            KIND_FAT16:
            begin
                entry = {16'd0, rdata[15:0]};
                limit = FAT16_EOC;
            end
            default:
            begin
                entry = rdata & FAT32_MASK;
                limit = FAT32_EOC;
            end
        endcase
        eoc = !s1_oor_reg && (entry >= limit);
        if (s1_oor_reg)
        begin
            next_val = 32'd0;
        end
        else if (eoc)
        begin
            next_val = EOC_MARK;
        end
        else
        begin
            next_val = entry;
        end
    end

    assign cl_m2   = {4'd0, s1_cl_reg} - 32'd2;
    assign product = cl_m2 * {24'd0, cfg.cluster_sectors};
    assign sector  = product + cfg.data_region_start;

    always_comb
    begin
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            next_reg   <= next_val;
            eoc_reg    <= eoc;
            sector_reg <= sector;
            oor_reg    <= s1_oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign successor    = next_reg;
    assign end_of_chain = eoc_reg;
    assign first_sector = sector_reg;
    assign out_of_range = oor_reg;

    // A write item never occupies the decode stage.
    a_write_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_lookup) |=> !s1_valid_reg)
        else $error("write item left a lookup in the decode stage");

    // The input only stalls behind a full, stalled output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without back-pressure");

    // An out-of-range result carries no successor and no end-of-chain flag.
    a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_reg) |-> (next_reg == 32'd0 && !eoc_reg))
        else $error("out-of-range result with a successor");

    // An end-of-chain result shows the all-ones mark.
    a_eoc_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eoc_reg) |-> (next_reg == EOC_MARK))
        else $error("end-of-chain result without the mark");

endmodule

`default_nettype wire
